@@ src/dppd_pkg.sv @@
`timescale 1ns / 1ps

package dppd_pkg;

  // Decode phase of the bit stream parser
  typedef enum logic [2:0] {
    PH_SEED,
    PH_CODE,
    PH_EXT,
    PH_DELTA,
    PH_DISCARD,
    PH_DONE
  } phase_t;

  // Microprogram addresses
  typedef enum logic [3:0] {
    U_IDLE,
    U_DISPATCH,
    U_SEED,
    U_CODE,
    U_REP,
    U_EXT,
    U_DELTA,
    U_DISC,
    U_END
  } upc_t;

  // Bit extraction size
  typedef enum logic [2:0] {
    TK_NONE,
    TK_SEED,
    TK_CODE,
    TK_EXT,
    TK_WIDTH
  } take_t;

  // Running value update
  typedef enum logic [1:0] {
    RV_HOLD,
    RV_LOAD,
    RV_DELTA
  } rv_op_t;

  // Phase bookkeeping after the step
  typedef enum logic [2:0] {
    PO_NONE,
    PO_SEED,
    PO_CODE,
    PO_REP,
    PO_EXT,
    PO_DELTA,
    PO_DISC
  } ph_op_t;

  // Branch kind
  typedef enum logic [2:0] {
    BR_WAIT,
    BR_DISPATCH,
    BR_GOTO,
    BR_CODE,
    BR_REP,
    BR_FINISH
  } br_t;

  typedef struct packed {
    take_t  take;
    rv_op_t rv_op;
    logic   emit;
    ph_op_t ph_op;
    br_t    br;
    upc_t   target;
  } uword_t;

  typedef logic [0:0] cfg_idx_t;

  localparam cfg_idx_t CFG_IMAGE_WIDTH  = 1'b0;
  localparam cfg_idx_t CFG_IMAGE_HEIGHT = 1'b1;

  localparam logic [3:0] SEED_BITS     = 4'd8;
  localparam logic [3:0] CODE_BITS     = 4'd3;
  localparam logic [3:0] EXT_BITS      = 4'd1;
  localparam logic [3:0] LITERAL_WIDTH = 4'd8;
  localparam logic [2:0] CODE_REPEAT   = 3'd0;
  localparam logic [2:0] CODE_EXTEND   = 3'd7;
  localparam logic [1:0] SLOT_LAST     = 2'd3;
  localparam logic [1:0] LAST_PLANE    = 2'd2;
  localparam logic [4:0] BUF_BITS      = 5'd16;
  localparam logic [4:0] BYTE_BITS     = 5'd8;

  // Control store: one word per microprogram step
  function automatic uword_t ucode_rom(input upc_t addr);
    uword_t w;
    unique case (addr)
      U_IDLE:     w = '{TK_NONE,  RV_HOLD,  1'b0, PO_NONE,  BR_WAIT,     U_DISPATCH};
      U_DISPATCH: w = '{TK_NONE,  RV_HOLD,  1'b0, PO_NONE,  BR_DISPATCH, U_END};
      U_SEED:     w = '{TK_SEED,  RV_LOAD,  1'b1, PO_SEED,  BR_GOTO,     U_DISPATCH};
      U_CODE:     w = '{TK_CODE,  RV_HOLD,  1'b0, PO_CODE,  BR_CODE,     U_DISPATCH};
      U_REP:      w = '{TK_NONE,  RV_HOLD,  1'b1, PO_REP,   BR_REP,      U_DISPATCH};
      U_EXT:      w = '{TK_EXT,   RV_HOLD,  1'b0, PO_EXT,   BR_GOTO,     U_DISPATCH};
      U_DELTA:    w = '{TK_WIDTH, RV_DELTA, 1'b1, PO_DELTA, BR_GOTO,     U_DISPATCH};
      U_DISC:     w = '{TK_WIDTH, RV_HOLD,  1'b0, PO_DISC,  BR_GOTO,     U_DISPATCH};
      U_END:      w = '{TK_NONE,  RV_HOLD,  1'b0, PO_NONE,  BR_FINISH,   U_IDLE};
      default:    w = '{TK_NONE,  RV_HOLD,  1'b0, PO_NONE,  BR_WAIT,     U_DISPATCH};
    endcase
    return w;
  endfunction

endpackage

@@ src/delta_plane_pixel_decoder_unit.sv @@
`timescale 1ns / 1ps

// Flow: a byte is taken while the sequencer is idle, then each parsed token costs a
//   dispatch step plus its own step (a repeat group spends one step per sample).
// A new byte is refused until every token of the last one is done, and a sample
//   may wait on a stalled output register; all is set by the single sequencer.
// Reset (rst_n low, synchronous): parser returns to "expect plane seed", counters,
//   bit buffer and output valid flag clear, image width and height return to 1.
module delta_plane_pixel_decoder_unit (
  input  logic                    clk,
  input  logic                    rst_n,
  // input byte channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              in_stream_byte,
  // result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [7:0]              out_sample_value,
  output logic [1:0]              out_plane_offset,
  output logic [15:0]             out_pixel_col,
  output logic [15:0]             out_pixel_row,
  output logic                    out_last_of_run,
  output logic                    out_image_done,
  // configuration write channel
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  dppd_pkg::cfg_idx_t      cfg_index,
  input  logic [15:0]             cfg_data
);
  import dppd_pkg::*;

  // Configuration registers
  logic [15:0] img_w_r, img_w_nxt;
  logic [15:0] img_h_r, img_h_nxt;

  // Parser state
  upc_t        upc_r, upc_nxt;
  phase_t      phase_r, phase_nxt;
  logic [15:0] buf_r, buf_nxt;
  logic [4:0]  held_r, held_nxt;
  logic [7:0]  rv_r, rv_nxt;
  logic [3:0]  width_r, width_nxt;
  logic [1:0]  slot_r, slot_nxt;
  logic [1:0]  rep_r, rep_nxt;
  logic [1:0]  plane_r, plane_nxt;
  logic [15:0] col_r, col_nxt;
  logic [15:0] row_r, row_nxt;

  // Pending sample: held back one step so the last sample of a byte can be flagged
  logic        pend_vld_r, pend_vld_nxt;
  logic [7:0]  pend_value_r, pend_value_nxt;
  logic [1:0]  pend_offset_r, pend_offset_nxt;
  logic [15:0] pend_col_r, pend_col_nxt;
  logic [15:0] pend_row_r, pend_row_nxt;
  logic        pend_done_r, pend_done_nxt;

  // Output register
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_value_r, out_value_nxt;
  logic [1:0]  out_offset_r, out_offset_nxt;
  logic [15:0] out_col_r, out_col_nxt;
  logic [15:0] out_row_r, out_row_nxt;
  logic        out_last_r, out_last_nxt;
  logic        out_done_r, out_done_nxt;

  // Datapath signals
  uword_t      uw;
  logic        accept;
  logic        can_move;
  logic        hold;
  logic        finish;
  logic [3:0]  need;
  logic        has_bits;
  logic [3:0]  take_k;
  logic [4:0]  sh;
  logic [15:0] shifted;
  logic [8:0]  mask9;
  logic [7:0]  take_v;
  logic [7:0]  half_v;
  logic [7:0]  delta_v;
  logic [7:0]  rv_new;
  logic [15:0] col_inc;
  logic [15:0] row_inc;
  logic [15:0] col_pos;
  logic        row_wrap;
  logic        full;
  logic        done;
  logic [2:0]  code;

  assign uw        = ucode_rom(upc_r);
  assign in_stall  = (upc_r != U_IDLE);
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign can_move  = !out_valid_r || !out_stall;
  assign finish    = (uw.br == BR_FINISH);
  // Freeze the step while a new sample would overrun a full output register
  assign hold      = (uw.emit || finish) && pend_vld_r && !can_move;

  // Bits needed by the current phase
  always_comb begin
    unique case (phase_r)
      PH_SEED: need = SEED_BITS;
      PH_CODE: need = CODE_BITS;
      PH_EXT:  need = EXT_BITS;
      default: need = width_r;
    endcase
  end
  assign has_bits = (held_r >= {1'b0, need});

  // Bit extraction, most significant first
  always_comb begin
    unique case (uw.take)
      TK_SEED:  take_k = SEED_BITS;
      TK_CODE:  take_k = CODE_BITS;
      TK_EXT:   take_k = EXT_BITS;
      TK_WIDTH: take_k = width_r;
      default:  take_k = 4'd0;
    endcase
  end
  assign sh      = held_r - {1'b0, take_k};
  assign shifted = buf_r >> sh;
  assign mask9   = (9'd1 << take_k) - 9'd1;
  assign take_v  = shifted[7:0] & mask9[7:0];
  assign code    = take_v[2:0];

  // Delta: odd adds half plus one, even subtracts half, full width is a literal
  assign half_v = {1'b0, take_v[7:1]};
  always_comb begin
    if (width_r == LITERAL_WIDTH) begin
      delta_v = take_v;
    end else if (take_v[0]) begin
      delta_v = rv_r + half_v + 8'd1;
    end else begin
      delta_v = rv_r - half_v;
    end
  end

  always_comb begin
    unique case (uw.rv_op)
      RV_LOAD:  rv_new = take_v;
      RV_DELTA: rv_new = delta_v;
      default:  rv_new = rv_r;
    endcase
  end

  // Serpentine position and plane fill detection
  assign col_inc  = col_r + 16'd1;
  assign row_inc  = row_r + 16'd1;
  assign col_pos  = row_r[0] ? (img_w_r - 16'd1 - col_r) : col_r;
  assign row_wrap = (col_inc >= img_w_r);
  assign full     = row_wrap && (row_inc >= img_h_r);
  assign done     = full && (plane_r >= LAST_PLANE);

  // Sequencer: next step address
  always_comb begin
    upc_nxt = upc_r;
    if (!hold) begin
      unique case (uw.br)
        BR_WAIT: begin
          if (accept && phase_r != PH_DONE) begin
            upc_nxt = uw.target;
          end
        end
        BR_DISPATCH: begin
          if (!has_bits) begin
            upc_nxt = uw.target;
          end else begin
            unique case (phase_r)
              PH_SEED:    upc_nxt = U_SEED;
              PH_CODE:    upc_nxt = U_CODE;
              PH_EXT:     upc_nxt = U_EXT;
              PH_DELTA:   upc_nxt = U_DELTA;
              PH_DISCARD: upc_nxt = U_DISC;
              default:    upc_nxt = uw.target;
            endcase
          end
        end
        BR_CODE: begin
          upc_nxt = (code == CODE_REPEAT) ? U_REP : uw.target;
        end
        BR_REP: begin
          upc_nxt = (full || rep_r == SLOT_LAST) ? uw.target : U_REP;
        end
        default: begin
          upc_nxt = uw.target;
        end
      endcase
    end
  end

  // Datapath: registers driven by the current control word
  always_comb begin
    img_w_nxt       = img_w_r;
    img_h_nxt       = img_h_r;
    phase_nxt       = phase_r;
    buf_nxt         = buf_r;
    held_nxt        = held_r;
    rv_nxt          = rv_r;
    width_nxt       = width_r;
    slot_nxt        = slot_r;
    rep_nxt         = rep_r;
    plane_nxt       = plane_r;
    col_nxt         = col_r;
    row_nxt         = row_r;
    pend_vld_nxt    = pend_vld_r;
    pend_value_nxt  = pend_value_r;
    pend_offset_nxt = pend_offset_r;
    pend_col_nxt    = pend_col_r;
    pend_row_nxt    = pend_row_r;
    pend_done_nxt   = pend_done_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_value_nxt   = out_value_r;
    out_offset_nxt  = out_offset_r;
    out_col_nxt     = out_col_r;
    out_row_nxt     = out_row_r;
    out_last_nxt    = out_last_r;
    out_done_nxt    = out_done_r;

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  img_w_nxt = cfg_data;
        CFG_IMAGE_HEIGHT: img_h_nxt = cfg_data;
        default:          img_w_nxt = img_w_r;
      endcase
    end

    if (uw.br == BR_WAIT) begin
      // Append the byte; drop it once the image is complete
      if (accept && phase_r != PH_DONE) begin
        buf_nxt  = {buf_r[7:0], in_stream_byte};
        held_nxt = (held_r >= BYTE_BITS) ? BUF_BITS : held_r + BYTE_BITS;
      end
    end else if (!hold) begin
      if (uw.take != TK_NONE) begin
        held_nxt = sh;
      end
      rv_nxt = rv_new;

      // Hand the previous sample on; mark it last when the byte is finished
      if (pend_vld_r && (uw.emit || finish)) begin
        out_valid_nxt  = 1'b1;
        out_value_nxt  = pend_value_r;
        out_offset_nxt = pend_offset_r;
        out_col_nxt    = pend_col_r;
        out_row_nxt    = pend_row_r;
        out_done_nxt   = pend_done_r;
        out_last_nxt   = finish;
      end
      if (finish) begin
        pend_vld_nxt = 1'b0;
      end

      if (uw.emit) begin
        pend_vld_nxt    = 1'b1;
        pend_value_nxt  = rv_new;
        pend_offset_nxt = 2'd2 - plane_r;
        pend_col_nxt    = col_pos;
        pend_row_nxt    = row_r;
        pend_done_nxt   = done;
        if (row_wrap) begin
          col_nxt = 16'd0;
          row_nxt = full ? 16'd0 : row_inc;
        end else begin
          col_nxt = col_inc;
        end
        if (full) begin
          phase_nxt = done ? PH_DONE : PH_SEED;
          if (!done) begin
            plane_nxt = plane_r + 2'd1;
          end
        end
      end

      unique case (uw.ph_op)
        PO_SEED: begin
          if (!full) begin
            phase_nxt = PH_CODE;
          end
        end
        PO_CODE: begin
          if (code == CODE_REPEAT) begin
            rep_nxt = 2'd0;
          end else if (code == CODE_EXTEND) begin
            phase_nxt = PH_EXT;
          end else begin
            width_nxt = {1'b0, code} + 4'd2;
            slot_nxt  = 2'd0;
            phase_nxt = PH_DELTA;
          end
        end
        PO_REP: begin
          if (!full) begin
            rep_nxt = rep_r + 2'd1;
          end
        end
        PO_EXT: begin
          width_nxt = {3'b000, take_v[0]} + 4'd1;
          slot_nxt  = 2'd0;
          phase_nxt = PH_DELTA;
        end
        PO_DELTA: begin
          if (full) begin
            // plane filled before the group ended: skip one more delta
            if (slot_r < SLOT_LAST && !done) begin
              phase_nxt = PH_DISCARD;
            end
          end else if (slot_r == SLOT_LAST) begin
            slot_nxt  = 2'd0;
            phase_nxt = PH_CODE;
          end else begin
            slot_nxt = slot_r + 2'd1;
          end
        end
        PO_DISC: begin
          phase_nxt = PH_SEED;
        end
        default: begin
          phase_nxt = phase_nxt;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r     <= 16'd1;
      img_h_r     <= 16'd1;
      upc_r       <= U_IDLE;
      phase_r     <= PH_SEED;
      buf_r       <= 16'd0;
      held_r      <= 5'd0;
      rv_r        <= 8'd0;
      width_r     <= 4'd0;
      slot_r      <= 2'd0;
      rep_r       <= 2'd0;
      plane_r     <= 2'd0;
      col_r       <= 16'd0;
      row_r       <= 16'd0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      img_w_r     <= img_w_nxt;
      img_h_r     <= img_h_nxt;
      upc_r       <= upc_nxt;
      phase_r     <= phase_nxt;
      buf_r       <= buf_nxt;
      held_r      <= held_nxt;
      rv_r        <= rv_nxt;
      width_r     <= width_nxt;
      slot_r      <= slot_nxt;
      rep_r       <= rep_nxt;
      plane_r     <= plane_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk) begin
    pend_value_r  <= pend_value_nxt;
    pend_offset_r <= pend_offset_nxt;
    pend_col_r    <= pend_col_nxt;
    pend_row_r    <= pend_row_nxt;
    pend_done_r   <= pend_done_nxt;
    out_value_r   <= out_value_nxt;
    out_offset_r  <= out_offset_nxt;
    out_col_r     <= out_col_nxt;
    out_row_r     <= out_row_nxt;
    out_last_r    <= out_last_nxt;
    out_done_r    <= out_done_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_sample_value = out_value_r;
  assign out_plane_offset = out_offset_r;
  assign out_pixel_col    = out_col_r;
  assign out_pixel_row    = out_row_r;
  assign out_last_of_run  = out_last_r;
  assign out_image_done   = out_done_r;

endmodule
